FILE: sv/sequential_list_insert_remove_core_assert.svh
// Assertion macros shared by the list core modules.
// Each macro expects ports named aclk and aresetn in the module that uses it.
`ifndef SEQUENTIAL_LIST_INSERT_REMOVE_CORE_ASSERT_SVH
`define SEQUENTIAL_LIST_INSERT_REMOVE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SLIR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SLIR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/slir_pkg.sv
// Shared types, codes and widths of the sequential list core.
// No dependencies; every module file imports this package.
package slir_pkg;

    localparam int CAPACITY_DEF   = 32;
    localparam int ITEM_WIDTH_DEF = 16;
    localparam int DUMP_LIMIT     = 32;

    // Port field widths
    localparam int OP_W       = 3;
    localparam int POS_W      = 6;
    localparam int IN_VAL_W   = 16;
    localparam int STATUS_W   = 2;
    localparam int OUT_VAL_W  = 16;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 7;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 32;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Input op codes
    localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_AT   = 3'd2;
    localparam logic [OP_W-1:0] OP_REM_HEAD = 3'd3;
    localparam logic [OP_W-1:0] OP_REM_TAIL = 3'd4;
    localparam logic [OP_W-1:0] OP_REM_AT   = 3'd5;
    localparam logic [OP_W-1:0] OP_DUMP     = 3'd6;

    // Command classes
    localparam logic [1:0] KIND_INS  = 2'd0;
    localparam logic [1:0] KIND_REM  = 2'd1;
    localparam logic [1:0] KIND_DUMP = 2'd2;
    localparam logic [1:0] KIND_NOP  = 2'd3;

    // Position selectors
    localparam logic [1:0] SEL_HEAD = 2'd0;
    localparam logic [1:0] SEL_TAIL = 2'd1;
    localparam logic [1:0] SEL_AT   = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd3;

    typedef struct packed {
        logic [1:0]       kind;
        logic [1:0]       sel;
        logic [POS_W-1:0] pos;
    } cmd_t;

endpackage

FILE: sv/slir_front.sv
// Front end: unpacks an input word and classifies its op into a command.
// Depends on slir_pkg.
module slir_front import slir_pkg::*; #(
    parameter int ITEM_WIDTH = ITEM_WIDTH_DEF
) (
    input  logic [S_TDATA_W-1:0]  s_tdata,  // op[2:0], position[8:3], item_value[24:9]
    output cmd_t                  cmd,
    output logic [ITEM_WIDTH-1:0] value
);

    localparam int VW = (ITEM_WIDTH > IN_VAL_W) ? ITEM_WIDTH : IN_VAL_W;

    logic [OP_W-1:0]     op;
    logic [IN_VAL_W-1:0] in_value;
    logic [VW-1:0]       value_wide;

    assign op         = s_tdata[OP_W-1:0];
    assign in_value   = s_tdata[OP_W+POS_W+IN_VAL_W-1:OP_W+POS_W];
    assign value_wide = VW'(in_value);
    // Only the low ITEM_WIDTH bits of the value are stored.
    assign value      = value_wide[ITEM_WIDTH-1:0];

    always_comb begin
        cmd.pos = s_tdata[OP_W+POS_W-1:OP_W];
        case (op)
            OP_INS_HEAD: begin cmd.kind = KIND_INS;  cmd.sel = SEL_HEAD; end
            OP_INS_TAIL: begin cmd.kind = KIND_INS;  cmd.sel = SEL_TAIL; end
            OP_INS_AT:   begin cmd.kind = KIND_INS;  cmd.sel = SEL_AT;   end
            OP_REM_HEAD: begin cmd.kind = KIND_REM;  cmd.sel = SEL_HEAD; end
            OP_REM_TAIL: begin cmd.kind = KIND_REM;  cmd.sel = SEL_TAIL; end
            OP_REM_AT:   begin cmd.kind = KIND_REM;  cmd.sel = SEL_AT;   end
            OP_DUMP:     begin cmd.kind = KIND_DUMP; cmd.sel = SEL_HEAD; end
            default:     begin cmd.kind = KIND_NOP;  cmd.sel = SEL_HEAD; end
        endcase
    end

endmodule

FILE: sv/slir_cmd_queue.sv
// Two-entry command queue that decouples the front end from the back end.
// Depends on slir_pkg and the assertion macro header.
`include "sequential_list_insert_remove_core_assert.svh"

module slir_cmd_queue import slir_pkg::*; #(
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data
);

    logic [DATA_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg, fill_next;
    logic              do_push, do_pop;

    assign push_ready = (fill_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `SLIR_ASSERT_IMP(a_fill_bound, 1'b1, fill_reg <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")

endmodule

FILE: sv/slir_back.sv
// Back end: executes list commands against the slot memory and drives the
// result register. Depends on slir_pkg and the assertion macro header.
`include "sequential_list_insert_remove_core_assert.svh"

module slir_back import slir_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int ITEM_WIDTH = ITEM_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  cmd_t                  q_cmd,
    input  logic [ITEM_WIDTH-1:0] q_value,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,  // status[1:0], out_value[17:2], out_index[23:18],
                                            // item_count[30:24], zero[31]
    output logic                  m_tlast
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int VW = (ITEM_WIDTH > OUT_VAL_W) ? ITEM_WIDTH : OUT_VAL_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    // Slot memory with one write port and a registered read port.
    logic [ITEM_WIDTH-1:0] slot_mem [CAPACITY];
    logic [ITEM_WIDTH-1:0] rd_data_reg;
    logic                  rd_en, wr_en;
    logic [AW-1:0]         rd_addr, wr_addr;
    logic [ITEM_WIDTH-1:0] wr_data;

    logic [1:0]            state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [1:0]            kind_reg, kind_next;
    logic [AW-1:0]         tgt_reg, tgt_next;
    logic [ITEM_WIDTH-1:0] val_reg, val_next;
    logic [ITEM_WIDTH-1:0] rv_reg, rv_next;
    logic [AW-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]         rd_cnt_reg, rd_cnt_next;
    logic [AW-1:0]         src_reg, src_next;
    logic                  pend_reg, pend_next;
    logic                  first_reg, first_next;

    logic                  m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]   m_status_reg, m_status_next;
    logic [OUT_VAL_W-1:0]  m_value_reg, m_value_next;
    logic [IDX_W-1:0]      m_index_reg, m_index_next;
    logic [CNT_W-1:0]      m_count_reg, m_count_next;
    logic                  m_last_reg, m_last_next;

    logic                  out_free;
    logic                  emit;
    logic [STATUS_W-1:0]   e_status;
    logic [ITEM_WIDTH-1:0] e_value;
    logic [VW-1:0]         e_value_wide;
    logic [AW-1:0]         e_index;
    logic [CW-1:0]         e_count;
    logic                  e_last;

    logic [CNT_W-1:0]      cnt7, pos7, tgt7, diff7, tail7, dump_n7;
    logic                  consume, issue;

    assign out_free = !m_valid_reg || m_tready;
    assign cnt7     = CNT_W'(count_reg);
    assign pos7     = CNT_W'(q_cmd.pos);
    assign tail7    = cnt7 - CNT_W'(1);
    assign dump_n7  = (cnt7 > CNT_W'(DUMP_LIMIT)) ? CNT_W'(DUMP_LIMIT) : cnt7;
    assign diff7    = cnt7 - tgt7;

    always_comb begin
        case (q_cmd.sel)
            SEL_HEAD: tgt7 = '0;
            SEL_TAIL: begin
                if (q_cmd.kind == KIND_INS) begin
                    tgt7 = cnt7;
                end else begin
                    tgt7 = (cnt7 == '0) ? '0 : tail7;
                end
            end
            default:  tgt7 = pos7;
        endcase
    end

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        kind_next   = kind_reg;
        tgt_next    = tgt_reg;
        val_next    = val_reg;
        rv_next     = rv_reg;
        rd_ptr_next = rd_ptr_reg;
        rd_cnt_next = rd_cnt_reg;
        src_next    = src_reg;
        pend_next   = pend_reg;
        first_next  = first_reg;
        q_pop       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = rd_ptr_reg;
        wr_en       = 1'b0;
        wr_addr     = tgt_reg;
        wr_data     = val_reg;
        emit        = 1'b0;
        e_status    = ST_OK;
        e_value     = '0;
        e_index     = '0;
        e_count     = count_reg;
        e_last      = 1'b1;
        consume     = 1'b0;
        issue       = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    kind_next = q_cmd.kind;
                    tgt_next  = tgt7[AW-1:0];
                    val_next  = q_value;
                    case (q_cmd.kind)
                        KIND_INS: begin
                            if (cnt7 >= CNT_W'(CAPACITY) || tgt7 > cnt7) begin
                                // Fullness takes precedence over a bad position.
                                if (out_free) begin
                                    emit     = 1'b1;
                                    e_status = (cnt7 >= CNT_W'(CAPACITY)) ? ST_FULL
                                                                          : ST_BAD_POS;
                                    q_pop    = 1'b1;
                                end
                            end else begin
                                q_pop       = 1'b1;
                                rd_ptr_next = tail7[AW-1:0];
                                rd_cnt_next = diff7[CW-1:0];
                                pend_next   = 1'b0;
                                state_next  = (diff7 == '0) ? S_FIN : S_WALK;
                            end
                        end
                        KIND_REM: begin
                            if (tgt7 >= cnt7) begin
                                if (out_free) begin
                                    emit     = 1'b1;
                                    e_status = ST_EMPTY;
                                    q_pop    = 1'b1;
                                end
                            end else begin
                                q_pop       = 1'b1;
                                rd_ptr_next = tgt7[AW-1:0];
                                rd_cnt_next = diff7[CW-1:0];
                                pend_next   = 1'b0;
                                first_next  = 1'b1;
                                state_next  = S_WALK;
                            end
                        end
                        KIND_DUMP: begin
                            if (cnt7 == '0) begin
                                if (out_free) begin
                                    emit     = 1'b1;
                                    e_status = ST_EMPTY;
                                    q_pop    = 1'b1;
                                end
                            end else begin
                                q_pop       = 1'b1;
                                rd_ptr_next = '0;
                                rd_cnt_next = dump_n7[CW-1:0];
                                pend_next   = 1'b0;
                                state_next  = S_WALK;
                            end
                        end
                        default: begin
                            if (out_free) begin
                                emit  = 1'b1;
                                q_pop = 1'b1;
                            end
                        end
                    endcase
                end
            end

            S_WALK: begin
                // A pending read is consumed while the next one goes out; a dump holds both while the output is busy.
                consume = pend_reg && ((kind_reg != KIND_DUMP) || out_free);
                issue   = (rd_cnt_reg != '0) && (!pend_reg || consume);
                if (consume) begin
                    case (kind_reg)
                        KIND_INS: begin
                            wr_en   = 1'b1;
                            wr_addr = src_reg + AW'(1);
                            wr_data = rd_data_reg;
                        end
                        KIND_REM: begin
                            if (first_reg) begin
                                rv_next    = rd_data_reg;
                                first_next = 1'b0;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = src_reg - AW'(1);
                                wr_data = rd_data_reg;
                            end
                        end
                        default: begin
                            emit    = 1'b1;
                            e_value = rd_data_reg;
                            e_index = src_reg;
                            e_last  = (rd_cnt_reg == '0);
                        end
                    endcase
                end
                if (issue) begin
                    rd_en       = 1'b1;
                    src_next    = rd_ptr_reg;
                    rd_cnt_next = rd_cnt_reg - CW'(1);
                    rd_ptr_next = (kind_reg == KIND_INS) ? rd_ptr_reg - AW'(1)
                                                         : rd_ptr_reg + AW'(1);
                    pend_next   = 1'b1;
                end else if (consume) begin
                    pend_next = 1'b0;
                end
                if (rd_cnt_reg == '0 && (!pend_reg || consume)) begin
                    state_next = (kind_reg == KIND_DUMP) ? S_IDLE : S_FIN;
                end
            end

            S_FIN: begin
                if (out_free) begin
                    emit       = 1'b1;
                    e_index    = tgt_reg;
                    state_next = S_IDLE;
                    if (kind_reg == KIND_INS) begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                        e_count    = count_reg + CW'(1);
                    end else begin
                        e_value    = rv_reg;
                        count_next = count_reg - CW'(1);
                        e_count    = count_reg - CW'(1);
                    end
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    assign e_value_wide = VW'(e_value);

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_value_next  = m_value_reg;
        m_index_next  = m_index_reg;
        m_count_next  = m_count_reg;
        m_last_next   = m_last_reg;
        if (emit) begin
            m_valid_next  = 1'b1;
            m_status_next = e_status;
            m_value_next  = e_value_wide[OUT_VAL_W-1:0];
            m_index_next  = IDX_W'(e_index);
            m_count_next  = CNT_W'(e_count);
            m_last_next   = e_last;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            first_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            first_reg   <= first_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        tgt_reg      <= tgt_next;
        val_reg      <= val_next;
        rv_reg       <= rv_next;
        rd_ptr_reg   <= rd_ptr_next;
        rd_cnt_reg   <= rd_cnt_next;
        src_reg      <= src_next;
        m_status_reg <= m_status_next;
        m_value_reg  <= m_value_next;
        m_index_reg  <= m_index_next;
        m_count_reg  <= m_count_next;
        m_last_reg   <= m_last_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_count_reg, m_index_reg, m_value_reg, m_status_reg};
    assign m_tlast  = m_last_reg;

    `SLIR_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CW'(CAPACITY), "count above capacity")
    `SLIR_ASSERT_IMP(a_pend_walk, pend_reg, state_reg == S_WALK, "read pending outside walk")
    `SLIR_ASSERT_NXT(a_count_fin, state_reg != S_FIN, $stable(count_reg),
                     "count changed outside finish")

endmodule

FILE: sv/sequential_list_insert_remove_core.sv
// A rejected op, an unused op or an empty dump is answered straight from idle; an append
// skips the walk; any other insert or remove first walks the entries from position to tail.
// A dump sends one word per cycle unless the output stalls, min(count, 32) words in all.
// The back end walks the slot memory one entry per cycle, holding while a dump's output
// stalls, and takes no new command until done; a two-entry queue lets the input run ahead.
// Reset (aresetn low, synchronous) empties the list; slot contents stay undefined.
module sequential_list_insert_remove_core import slir_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int ITEM_WIDTH = ITEM_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // op[2:0], position[8:3], item_value[24:9]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // status[1:0], out_value[17:2], out_index[23:18],
                                           // item_count[30:24]
    output logic                 m_tlast
);

    localparam int QDATA_W = $bits(cmd_t) + ITEM_WIDTH;

    cmd_t                  f_cmd, q_cmd;
    logic [ITEM_WIDTH-1:0] f_value, q_value;
    logic [QDATA_W-1:0]    q_data;
    logic                  q_valid, q_pop;

    slir_front #(
        .ITEM_WIDTH(ITEM_WIDTH)
    ) u_front (
        .s_tdata(s_tdata),
        .cmd    (f_cmd),
        .value  (f_value)
    );

    slir_cmd_queue #(
        .DATA_W(QDATA_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(s_tvalid),
        .push_ready(s_tready),
        .push_data ({f_value, f_cmd}),
        .pop_valid (q_valid),
        .pop       (q_pop),
        .pop_data  (q_data)
    );

    assign q_cmd   = q_data[$bits(cmd_t)-1:0];
    assign q_value = q_data[QDATA_W-1:$bits(cmd_t)];

    slir_back #(
        .CAPACITY  (CAPACITY),
        .ITEM_WIDTH(ITEM_WIDTH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_cmd   (q_cmd),
        .q_value (q_value),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

endmodule
